@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int SYM_W     = 8;
  localparam int LEN_W     = 6;
  localparam int CODE_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int PEND_W    = 7;
  localparam int CNT_W     = 3;
  localparam int MAX_BYTES = 4;
  localparam int NB_W      = 3;
  localparam int TOT_W     = 7;
  localparam int ACC_W     = PEND_W + CODE_W;
  localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
  localparam int EFF_MAX_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic                                vld;
    logic [NB_W-1:0]                     cnt;
    logic [MAX_BYTES-1:0][BYTE_W-1:0]    bytes;
  } obuf_load_t;

endpackage

@@ hw/rtl/huffman_code_bit_packer_top.sv @@
// Huffman code bit packer, most significant bit first.
// Input words carry an action in in_tuser: load a table entry, encode a
// symbol or flush the partial byte. Loads write a 256-entry code table;
// encodes append the symbol's code to a pending-bit accumulator and emit
// each completed byte; a flush pads the pending bits with zeros on the right
// and emits them as one byte. Output words carry one byte each, with tlast
// set on the final byte caused by one input word.
// The first byte of an input word is presented once the output buffer is
// loaded: the table is read into the packing stage at the accepting edge,
// and the packing logic loads the output buffer when the buffer is free.
// Throughput: one input word per cycle while words produce at most one byte
// and the receiver takes each byte; a word that produces up to four bytes
// holds the buffer as its bytes drain, one per cycle while out_tready is high.
// Reset clears the table's valid flags, so every entry reads as length zero,
// and empties the accumulator and the pipeline; no clearing pass is needed.
// When the receiver stalls, bytes wait in the output buffer, one word may
// wait in the packing stage, and in_tready falls until the buffer can take
// the next group of bytes.
`include "assert_macros.svh"

module huffman_code_bit_packer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // symbol[7:0], code_length[13:8], code_bits[45:14], zero
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tlast   // last_byte
);

  logic                              in_accept;
  hcbp_pkg::action_t                 act_in;
  logic [hcbp_pkg::SYM_W-1:0]        sym_in;
  logic [hcbp_pkg::LEN_W-1:0]        len_in, len_sat;
  logic [hcbp_pkg::CODE_W-1:0]       bits_in;
  logic                              sym_ok_in;
  logic [hcbp_pkg::ADDR_W-1:0]       addr_in;
  logic                              tbl_we;
  hcbp_pkg::entry_t                  wr_entry, rd_entry;
  logic [$bits(hcbp_pkg::entry_t)-1:0] rd_data;

  logic [hcbp_pkg::SYMBOL_COUNT-1:0] ent_vld_r;
  logic                              s1_vld_r, s1_vld_nxt;
  hcbp_pkg::action_t                 s1_act_r;
  logic                              s1_sym_ok_r;
  logic                              s1_ent_vld_r;
  logic                              s1_fire;

  logic [hcbp_pkg::PEND_W-1:0]       pend_r, pend_nxt;
  logic [hcbp_pkg::CNT_W-1:0]        pcnt_r, pcnt_nxt;

  logic [hcbp_pkg::LEN_W-1:0]        len_eff;
  logic [hcbp_pkg::CODE_W-1:0]       code_al;
  logic [hcbp_pkg::ACC_W-1:0]        aligned, rem;
  logic [hcbp_pkg::TOT_W-1:0]        total;
  logic [hcbp_pkg::NB_W-1:0]         nb, res_cnt;
  logic [hcbp_pkg::MAX_BYTES-1:0][hcbp_pkg::BYTE_W-1:0] res_bytes;
  hcbp_pkg::obuf_load_t              ld;
  logic                              obuf_free;

  assign in_accept = in_tvalid && in_tready;
  assign act_in    = hcbp_pkg::action_t'(in_tuser);
  assign sym_in    = in_tdata[7:0];
  assign len_in    = in_tdata[13:8];
  assign bits_in   = in_tdata[45:14];
  assign sym_ok_in = ({1'b0, sym_in} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOL_COUNT));
  assign addr_in   = sym_in[hcbp_pkg::ADDR_W-1:0];
  assign len_sat   = (len_in > hcbp_pkg::LEN_W'(hcbp_pkg::EFF_MAX_LEN)) ?
                     hcbp_pkg::LEN_W'(hcbp_pkg::EFF_MAX_LEN) : len_in;
  assign tbl_we    = in_accept && (act_in == hcbp_pkg::ACT_LOAD) && sym_ok_in;
  assign wr_entry  = '{len: len_sat, code: bits_in};

  hcbp_ram #(
    .WIDTH ($bits(hcbp_pkg::entry_t)),
    .DEPTH (hcbp_pkg::SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (addr_in),
    .wdata (wr_entry),
    .re    (in_accept),
    .raddr (addr_in),
    .rdata (rd_data)
  );

  assign rd_entry = hcbp_pkg::entry_t'(rd_data);

  // Packing: pending bits are kept left-aligned with zeros below them.
  always_comb begin
    len_eff = s1_ent_vld_r ? rd_entry.len : '0;
    code_al = rd_entry.code << (hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W) - len_eff);
    aligned = {pend_r, hcbp_pkg::CODE_W'(0)} |
              ({code_al, hcbp_pkg::PEND_W'(0)} >> pcnt_r);
    total   = hcbp_pkg::TOT_W'(pcnt_r) + hcbp_pkg::TOT_W'(len_eff);
    nb      = hcbp_pkg::NB_W'(total >> 3);
    rem     = aligned << {nb, 3'b000};
    for (int k = 0; k < hcbp_pkg::MAX_BYTES; k++) begin
      res_bytes[k] = aligned[hcbp_pkg::ACC_W-1-hcbp_pkg::BYTE_W*k -: hcbp_pkg::BYTE_W];
    end
    res_cnt  = '0;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    case (s1_act_r)
      hcbp_pkg::ACT_ENCODE: begin
        if (s1_sym_ok_r && (len_eff != '0)) begin
          res_cnt  = nb;
          pend_nxt = rem[hcbp_pkg::ACC_W-1 -: hcbp_pkg::PEND_W];
          pcnt_nxt = total[hcbp_pkg::CNT_W-1:0];
        end
      end
      hcbp_pkg::ACT_FLUSH: begin
        if (pcnt_r != '0) begin
          res_cnt      = hcbp_pkg::NB_W'(1);
          res_bytes[0] = {pend_r, 1'b0};
          pend_nxt     = '0;
          pcnt_nxt     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign s1_fire   = s1_vld_r && ((res_cnt == '0) || obuf_free);
  assign in_tready = !s1_vld_r || s1_fire;
  assign ld        = '{vld: s1_fire && (res_cnt != '0), cnt: res_cnt, bytes: res_bytes};

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_accept) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_act_r     <= act_in;
      s1_sym_ok_r  <= sym_ok_in;
      s1_ent_vld_r <= ent_vld_r[addr_in];
    end
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      ent_vld_r <= '0;
      pend_r    <= '0;
      pcnt_r    <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (tbl_we) begin
        ent_vld_r[addr_in] <= 1'b1;
      end
      if (s1_fire) begin
        pend_r <= pend_nxt;
        pcnt_r <= pcnt_nxt;
      end
    end
  end

  hcbp_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld         (ld),
    .free       (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `ASSERT_IMPL(a_pend_aligned, clk, rst_n, 1'b1, (pend_r & (7'h7F >> pcnt_r)) == '0)
  `ASSERT_NEXT(a_s1_hold, clk, rst_n, s1_vld_r && !s1_fire, s1_vld_r && $stable(s1_act_r) && $stable(pcnt_r))

endmodule

@@ hw/rtl/hcbp_ram.sv @@
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/hcbp_obuf.sv @@
`include "assert_macros.svh"

module hcbp_obuf (
  input  logic                clk,
  input  logic                rst_n,
  input  hcbp_pkg::obuf_load_t ld,
  output logic                free,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,  // out_byte[7:0]
  output logic                out_tlast   // last_byte
);

  logic [hcbp_pkg::MAX_BYTES-1:0][hcbp_pkg::BYTE_W-1:0] data_r, data_nxt;
  logic [hcbp_pkg::NB_W-1:0] cnt_r, cnt_nxt;
  logic pop;

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = data_r[0];
  assign out_tlast  = (cnt_r == hcbp_pkg::NB_W'(1));
  assign pop        = out_tvalid && out_tready;
  assign free       = (cnt_r == '0) || (out_tlast && pop);

  always_comb begin
    data_nxt = data_r;
    cnt_nxt  = cnt_r;
    if (ld.vld) begin
      data_nxt = ld.bytes;
      cnt_nxt  = ld.cnt;
    end else if (pop) begin
      data_nxt = data_r >> hcbp_pkg::BYTE_W;
      cnt_nxt  = cnt_r - hcbp_pkg::NB_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `ASSERT_IMPL(a_load_when_free, clk, rst_n, ld.vld, free)
  `ASSERT_NEXT(a_drain_continues, clk, rst_n, pop && (cnt_r > hcbp_pkg::NB_W'(1)), out_tvalid && (cnt_r == $past(cnt_r) - hcbp_pkg::NB_W'(1)))

endmodule

@@ test/tb_huffman_code_bit_packer_top.sv @@
module tb_huffman_code_bit_packer_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACTION_RESERVED = 2'd3;
  localparam int RANDOM_WORDS = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  sym;
    logic [5:0]  len;
    logic [31:0] bits;
    logic        typed;
    logic [2:0]  n;
    logic [31:0] bytes;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  logic [hcbp_pkg::LEN_W-1:0]  model_len [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::CODE_W-1:0] model_code [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::PEND_W-1:0] model_pend_bits;
  logic [hcbp_pkg::CNT_W-1:0]  model_pend_cnt;

  out_word_t expected_bytes[$];
  int        mismatch_count = 0;
  int        burst_left = 0;
  bit        hold_req = 0;
  bit        hold_done = 0;

  // Bytes in the expectation columns are listed first byte in the top bits.
  stim_row_t directed_rows [25] = '{
    '{hcbp_pkg::ACT_ENCODE, 8'h00, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{ACTION_RESERVED,      8'hFF, 6'd63, 32'hFFFFFFFF, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_LOAD,   8'hFF, 6'd32, 32'hFFFFFFFF, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'hFF, 6'd0,  32'h00000000, 1'b1, 3'd4, 32'hFFFFFFFF},
    '{hcbp_pkg::ACT_LOAD,   8'h00, 6'd63, 32'hA5A5A5A5, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h00, 6'd0,  32'h00000000, 1'b1, 3'd4, 32'hA5A5A5A5},
    '{hcbp_pkg::ACT_LOAD,   8'h01, 6'd1,  32'hFFFFFFFF, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h01, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h01, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h01, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 6'd0,  32'h00000000, 1'b1, 3'd1, 32'hE0000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_LOAD,   8'h02, 6'd7,  32'h0000007F, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h02, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'hFF, 6'd0,  32'h00000000, 1'b1, 3'd4, 32'hFFFFFFFF},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 6'd0,  32'h00000000, 1'b1, 3'd1, 32'hFE000000},
    '{hcbp_pkg::ACT_LOAD,   8'h03, 6'd0,  32'hFFFFFFFF, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h03, 6'd0,  32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_LOAD,   8'h04, 6'd33, 32'h00000000, 1'b1, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h01, 6'd0,  32'h00000000, 1'b0, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h04, 6'd0,  32'h00000000, 1'b0, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_LOAD,   8'h05, 6'd5,  32'hFFFFFFF5, 1'b0, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_ENCODE, 8'h05, 6'd0,  32'h00000000, 1'b0, 3'd0, 32'h00000000},
    '{hcbp_pkg::ACT_FLUSH,  8'h00, 6'd0,  32'h00000000, 1'b0, 3'd0, 32'h00000000}
  };

  huffman_code_bit_packer_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void pack_code_word(input logic [1:0] act, input logic [7:0] sym,
                                         input logic [5:0] len, input logic [31:0] bits,
                                         output logic [2:0] n, output logic [31:0] bytes);
    logic [5:0]  l;
    logic [63:0] acc;
    logic [63:0] tmp;
    int          total;
    int          idx;
    n = 3'd0;
    bytes = 32'd0;
    idx = 0;
    case (act)
      hcbp_pkg::ACT_LOAD: begin
        if (sym < hcbp_pkg::SYMBOL_COUNT) begin
          l = len;
          if (l > hcbp_pkg::MAX_CODE_LEN) l = hcbp_pkg::LEN_W'(hcbp_pkg::MAX_CODE_LEN);
          if (l > hcbp_pkg::CODE_W) l = hcbp_pkg::LEN_W'(hcbp_pkg::CODE_W);
          model_len[sym] = l;
          model_code[sym] = bits;
        end
      end
      hcbp_pkg::ACT_ENCODE: begin
        if (sym < hcbp_pkg::SYMBOL_COUNT && model_len[sym] != 0) begin
          l = model_len[sym];
          acc = ({57'd0, model_pend_bits} << l)
              | ({32'd0, model_code[sym]} & ((64'd1 << l) - 64'd1));
          total = int'(model_pend_cnt) + int'(l);
          while (total >= hcbp_pkg::BYTE_W && idx < hcbp_pkg::MAX_BYTES) begin
            tmp = acc >> (total - hcbp_pkg::BYTE_W);
            bytes[31 - 8 * idx -: 8] = tmp[7:0];
            idx++;
            total -= hcbp_pkg::BYTE_W;
          end
          tmp = acc & ((64'd1 << total) - 64'd1);
          model_pend_bits = tmp[hcbp_pkg::PEND_W-1:0];
          model_pend_cnt = total[hcbp_pkg::CNT_W-1:0];
          n = idx[2:0];
        end
      end
      hcbp_pkg::ACT_FLUSH: begin
        if (model_pend_cnt != 0) begin
          bytes[31:24] = {1'b0, model_pend_bits} << (hcbp_pkg::BYTE_W - model_pend_cnt);
          n = 3'd1;
          model_pend_bits = '0;
          model_pend_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_bytes(input logic [2:0] n, input logic [31:0] bytes);
    out_word_t w;
    for (int k = 0; k < n; k++) begin
      w.data = bytes[31 - 8 * k -: 8];
      w.last = (k == n - 1);
      expected_bytes.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [8:0] got,
                                 input logic [8:0] want);
    mismatch_count++;
    $display("mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
  endtask

  task automatic send_word(input logic [1:0] act, input logic [7:0] sym,
                           input logic [5:0] len, input logic [31:0] bits);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, bits, len, sym};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(0, 12);
    end
  endtask

  always @(posedge clk) begin : out_check
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected word", {out_tlast, out_tdata}, 9'd0);
      end else begin
        want = expected_bytes.pop_front();
        if (out_tdata !== want.data)
          report_mismatch("byte", {1'b0, out_tdata}, {1'b0, want.data});
        if (out_tlast !== want.last)
          report_mismatch("last flag", {8'd0, out_tlast}, {8'd0, want.last});
      end
    end
  end

  initial begin : receiver
    int mode;
    int seg;
    out_tready <= 1'b0;
    repeat (9) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(8, 60);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (k % 4) != 0;
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("timeout after %0d cycles with no word moving", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  act;
    logic [7:0]  sym;
    logic [5:0]  len;
    logic [31:0] bits;
    logic [2:0]  n;
    logic [31:0] bytes;
    logic [7:0]  live_syms[$];
    int          count;
    int          r;
    bit          paused;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    for (int s = 0; s < hcbp_pkg::SYMBOL_COUNT; s++) begin
      model_len[s] = '0;
      model_code[s] = '0;
    end
    model_pend_bits = '0;
    model_pend_cnt = '0;
    count = 0;
    paused = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].act, directed_rows[i].sym, directed_rows[i].len,
                directed_rows[i].bits);
      pack_code_word(directed_rows[i].act, directed_rows[i].sym, directed_rows[i].len,
                     directed_rows[i].bits, n, bytes);
      if (directed_rows[i].typed) queue_bytes(directed_rows[i].n, directed_rows[i].bytes);
      else queue_bytes(n, bytes);
      pace();
    end
    for (int s = 0; s < 6; s++) live_syms.push_back(s[7:0]);

    while (count < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      sym = 8'($urandom_range(0, 255));
      len = 6'($urandom_range(0, 63));
      bits = $urandom;
      if (r < 20) begin
        act = hcbp_pkg::ACT_LOAD;
        r = $urandom_range(0, 99);
        if (r < 40) len = 6'($urandom_range(1, 8));
        else if (r < 70) len = 6'($urandom_range(9, 32));
        else if (r < 80) len = 6'd0;
        else len = 6'($urandom_range(33, 63));
        if (len != 0) live_syms.push_back(sym);
      end else if (r < 82) begin
        act = hcbp_pkg::ACT_ENCODE;
        if ($urandom_range(0, 99) < 85)
          sym = live_syms[$urandom_range(0, live_syms.size() - 1)];
      end else if (r < 94) begin
        act = hcbp_pkg::ACT_FLUSH;
      end else begin
        act = ACTION_RESERVED;
      end
      send_word(act, sym, len, bits);
      pack_code_word(act, sym, len, bits, n, bytes);
      queue_bytes(n, bytes);
      count++;
      if (count >= 150) hold_req = 1'b1;
      if (count >= 300 && !paused) begin
        paused = 1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0) @(posedge clk);
      end
      pace();
    end

    in_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
